// ----- rtl/core/lsae_pkg.sv -----
// shared types and constants of the line sensor angle estimator
// used by lsae_scan, the top level and lsae_checker, no dependencies of its own
package lsae_pkg;

    localparam int NUM_CH      = 5;
    localparam int CH_IDX_W    = 3;
    localparam int LINE_THRESH = 8;
    localparam int EDGE_ERR    = 200;
    localparam int ERR_W       = 9;
    localparam int STEER_W     = 8;
    localparam int SPEED_W     = 10;
    localparam int DELAY_W     = 8;
    localparam int QUOT_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int M_TDATA_W   = 24;
    localparam int RESET_SPEED = 400;
    localparam int RESET_DELAY = 25;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASELINE_CH0 = 3'd0,
        REG_BASELINE_CH1 = 3'd1,
        REG_BASELINE_CH2 = 3'd2,
        REG_BASELINE_CH3 = 3'd3,
        REG_BASELINE_CH4 = 3'd4,
        REG_RUN_SPEED    = 3'd5,
        REG_STOP_DELAY   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETUP,
        ST_DIV_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    // outcome of the channel scan
    typedef struct packed {
        logic                found;
        logic [CH_IDX_W-1:0] sel;
        logic                all_on;
    } scan_res_t;

endpackage

// ----- rtl/core/lsae_scan.sv -----
// serial channel scan: one channel per cycle through a shift line
// subtracts the baseline, clamps at zero, tracks the first maximum above threshold
// depends on lsae_pkg
module lsae_scan #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           start_i,
    input  logic [lsae_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   samples_i,
    input  logic [lsae_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   baseline_i,
    output logic                                           done_o,
    output lsae_pkg::scan_res_t                            res_o,
    output logic [lsae_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   ch_o
);

    localparam int SB = SAMPLE_BITS;

    logic [lsae_pkg::NUM_CH-1:0][SB-1:0] samp_reg;
    logic [lsae_pkg::NUM_CH-1:0][SB-1:0] ch_reg;
    logic [lsae_pkg::CH_IDX_W-1:0]       cnt_reg;
    logic                                active_reg;
    logic                                done_reg;
    logic [SB-1:0]                       best_reg;
    lsae_pkg::scan_res_t                 res_reg;

    logic [SB:0]   diff;
    logic [SB-1:0] val;

    always_comb begin
        diff = {1'b0, samp_reg[0]} - {1'b0, baseline_i[cnt_reg]};
        val  = diff[SB] ? '0 : diff[SB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end else if (active_reg) begin
                if (cnt_reg == lsae_pkg::CH_IDX_W'(lsae_pkg::NUM_CH - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // payload path
    always_ff @(posedge aclk) begin
        if (start_i) begin
            samp_reg       <= samples_i;
            best_reg       <= SB'(lsae_pkg::LINE_THRESH);
            res_reg.found  <= 1'b0;
            res_reg.sel    <= '0;
            res_reg.all_on <= 1'b1;
        end else if (active_reg) begin
            samp_reg <= {{SB{1'b0}}, samp_reg[lsae_pkg::NUM_CH-1:1]};
            ch_reg   <= {val, ch_reg[lsae_pkg::NUM_CH-1:1]};
            if (val > best_reg) begin
                best_reg      <= val;
                res_reg.sel   <= cnt_reg;
                res_reg.found <= 1'b1;
            end
            if (val < SB'(lsae_pkg::LINE_THRESH)) begin
                res_reg.all_on <= 1'b0;
            end
        end
    end

    assign done_o = done_reg;
    assign res_o  = res_reg;
    assign ch_o   = ch_reg;

endmodule

// ----- rtl/core/lsae_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// magnitudes only, the caller handles signs; depends on lsae_pkg for nothing
module lsae_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 13,
    parameter int Q_W   = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic [NUM_W-1:0] num_i,
    input  logic [DEN_W-1:0] den_i,
    output logic             done_o,
    output logic [Q_W-1:0]   quot_o
);

    localparam int DSH_W = DEN_W + Q_W - 1;
    localparam int W     = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsh_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(Q_W - 1);
            end else if (active_reg) begin
                if (cnt_reg == '0) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            rem_reg  <= W'(num_i);
            dsh_reg  <= W'(den_i) << (Q_W - 1);
            quot_reg <= '0;
        end else if (active_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;

endmodule

// ----- rtl/core/line_sensor_angle_estimator.sv -----
// top level of the line sensor angle estimator
// depends on lsae_pkg, lsae_scan and lsae_div
//
// usage
// - s_ channel: one beat is one frame of five raw sensor samples
// - m_ channel: one beat per frame with the halved steering error, the sticky
//   line_done flag and the speed command
// - cfg channel: register writes (index 0..4 baselines, 5 run_speed,
//   6 stop_delay); cfg_ready is always high, write only while the block is idle
// - frames are taken one at a time: after a beat on s_ the block scans the five
//   channels serially (one per cycle), sets up the interpolation and runs a
//   bit-serial divider that yields seven quotient bits
// - when no channel is above threshold the divider is skipped and the block goes
//   from the setup straight to the finish step; a new frame is taken only after
//   the result is registered and the block is back in idle
// - a finished result waits in the output register; the block takes the next
//   frame while it waits, and only holds that frame at its last step until the
//   receiver has taken the previous beat
// - reset clears the state: baselines 0, run_speed 400, stop countdown 25
//   (the stop_delay reset value), last error 0, line_done clear, no beat pending
module line_sensor_angle_estimator #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    // s_tdata: sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4
    input  logic [((lsae_pkg::NUM_CH*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    // m_tdata: steer_error[7:0], line_done[8], speed_command[18:9]
    output logic [lsae_pkg::M_TDATA_W-1:0]                     m_tdata,
    output logic                                               m_tvalid,
    input  logic                                               m_tready,
    input  logic                                               cfg_valid,
    output logic                                               cfg_ready,
    input  logic [lsae_pkg::CFG_IDX_W-1:0]                     cfg_index,
    input  logic [lsae_pkg::CFG_DATA_W-1:0]                    cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SB + 7;   // holds 100 * channel
    localparam int DEN_W = SB + 1;   // holds sum of two channels
    localparam int ERR_W = lsae_pkg::ERR_W;

    // configuration registers
    logic [lsae_pkg::NUM_CH-1:0][SB-1:0]  baseline_reg;
    logic [lsae_pkg::SPEED_W-1:0]         run_speed_reg;

    // frame-to-frame state
    logic signed [ERR_W-1:0]              last_err_reg;
    logic                                 end_seen_reg;
    logic signed [ERR_W-1:0]              stop_cnt_reg;

    lsae_pkg::state_t                     state_reg, state_next;

    // interpolation setup
    logic [NUM_W-1:0]                     num_reg, num_next;
    logic [DEN_W-1:0]                     den_reg, den_next;
    logic                                 neg_reg, neg_next;
    logic signed [ERR_W-1:0]              base_reg, base_next;

    // output register
    logic                                 m_tvalid_reg;
    logic [lsae_pkg::M_TDATA_W-1:0]       m_tdata_reg;

    logic                                 scan_start;
    logic                                 scan_done;
    lsae_pkg::scan_res_t                  scan_res;
    logic [lsae_pkg::NUM_CH-1:0][SB-1:0]  ch;
    logic                                 div_start;
    logic                                 div_done;
    logic [lsae_pkg::QUOT_W-1:0]          quot;
    logic                                 load_out;
    logic                                 out_free;

    logic signed [ERR_W-1:0]              err_fin;
    logic [ERR_W-1:0]                     err_adj;
    logic                                 end_seen_next;
    logic signed [ERR_W-1:0]              stop_cnt_next;
    logic [lsae_pkg::SPEED_W-1:0]         speed;

    function automatic logic [NUM_W-1:0] mul100(input logic [SB-1:0] x);
        logic [NUM_W-1:0] xe;
        xe = NUM_W'(x);
        return (xe << 6) + (xe << 5) + (xe << 2);
    endfunction

    function automatic logic [NUM_W-1:0] mul50(input logic [SB-1:0] x);
        logic [NUM_W-1:0] xe;
        xe = NUM_W'(x);
        return (xe << 5) + (xe << 4) + (xe << 1);
    endfunction

    // magnitude and sign of a - b
    function automatic logic [SB:0] abs_diff(input logic [SB-1:0] a,
                                             input logic [SB-1:0] b);
        logic [SB:0] d;
        logic [SB:0] m;
        d = {1'b0, a} - {1'b0, b};
        m = d[SB] ? (~d + 1'b1) : d;
        return {d[SB], m[SB-1:0]};
    endfunction

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // channel scan and divider
    // ---------------------------------------------------------------------
    lsae_scan #(
        .SAMPLE_BITS(SB)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (scan_start),
        .samples_i (s_tdata[lsae_pkg::NUM_CH*SB-1:0]),
        .baseline_i(baseline_reg),
        .done_o    (scan_done),
        .res_o     (scan_res),
        .ch_o      (ch)
    );

    lsae_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W),
        .Q_W  (lsae_pkg::QUOT_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start_i(div_start),
        .num_i  (num_reg),
        .den_i  (den_reg),
        .done_o (div_done),
        .quot_o (quot)
    );

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsae_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        scan_start = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            lsae_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    scan_start = 1'b1;
                    state_next = lsae_pkg::ST_SCAN;
                end
            end
            lsae_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = lsae_pkg::ST_SETUP;
                end
            end
            lsae_pkg::ST_SETUP: begin
                // no channel above threshold: no division needed
                state_next = scan_res.found ? lsae_pkg::ST_DIV_START
                                            : lsae_pkg::ST_FINISH;
            end
            lsae_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = lsae_pkg::ST_DIV;
            end
            lsae_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = lsae_pkg::ST_FINISH;
                end
            end
            lsae_pkg::ST_FINISH: begin
                // hold until the previous beat has been taken
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = lsae_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsae_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // interpolation setup: numerator magnitude, denominator, base and sign
    // ---------------------------------------------------------------------
    always_comb begin
        logic [SB:0] ad;
        ad        = '0;
        num_next  = '0;
        den_next  = DEN_W'(1);
        neg_next  = 1'b0;
        base_next = '0;
        unique case (scan_res.sel)
            3'd0: begin
                // left edge: -200 + 100*ch1 / (ch0 + ch1)
                num_next  = mul100(ch[0+1]);
                den_next  = {1'b0, ch[0]} + {1'b0, ch[1]};
                base_next = -ERR_W'(200);
            end
            3'd1: begin
                ad        = abs_diff(ch[2], ch[0]);
                num_next  = mul50(ad[SB-1:0]);
                neg_next  = ad[SB];
                den_next  = DEN_W'(ch[1]);
                base_next = -ERR_W'(100);
            end
            3'd2: begin
                ad        = abs_diff(ch[3], ch[1]);
                num_next  = mul50(ad[SB-1:0]);
                neg_next  = ad[SB];
                den_next  = DEN_W'(ch[2]);
                base_next = '0;
            end
            3'd3: begin
                ad        = abs_diff(ch[4], ch[2]);
                num_next  = mul50(ad[SB-1:0]);
                neg_next  = ad[SB];
                den_next  = DEN_W'(ch[3]);
                base_next = ERR_W'(100);
            end
            3'd4: begin
                // right edge: 200 - 100*ch3 / (ch3 + ch4)
                num_next  = mul100(ch[3]);
                neg_next  = 1'b1;
                den_next  = {1'b0, ch[3]} + {1'b0, ch[4]};
                base_next = ERR_W'(200);
            end
            default: begin
                num_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lsae_pkg::ST_SETUP) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            neg_reg  <= neg_next;
            base_reg <= base_next;
        end
    end

    // ---------------------------------------------------------------------
    // final error, countdown and result
    // ---------------------------------------------------------------------
    always_comb begin
        logic signed [ERR_W-1:0] q_ext;
        q_ext = $signed({{(ERR_W-lsae_pkg::QUOT_W){1'b0}}, quot});
        if (scan_res.found) begin
            err_fin = neg_reg ? (base_reg - q_ext) : (base_reg + q_ext);
        end else if (last_err_reg > 0) begin
            err_fin = ERR_W'(lsae_pkg::EDGE_ERR);
        end else if (last_err_reg < 0) begin
            err_fin = -ERR_W'(lsae_pkg::EDGE_ERR);
        end else begin
            err_fin = '0;
        end

        // halve toward zero: add one to negative values before the shift
        err_adj = err_fin + {{(ERR_W-1){1'b0}}, err_fin[ERR_W-1]};

        end_seen_next = end_seen_reg || scan_res.all_on;
        if (end_seen_next && !stop_cnt_reg[ERR_W-1]) begin
            stop_cnt_next = stop_cnt_reg - 1'b1;
        end else begin
            stop_cnt_next = stop_cnt_reg;
        end
        speed = stop_cnt_next[ERR_W-1] ? '0 : run_speed_reg;
    end

    // configuration writes and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg   <= '0;
            run_speed_reg  <= lsae_pkg::SPEED_W'(lsae_pkg::RESET_SPEED);
            last_err_reg   <= '0;
            end_seen_reg   <= 1'b0;
            stop_cnt_reg   <= ERR_W'(lsae_pkg::RESET_DELAY);
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (lsae_pkg::cfg_reg_t'(cfg_index))
                    lsae_pkg::REG_BASELINE_CH0: baseline_reg[0] <= cfg_data[SB-1:0];
                    lsae_pkg::REG_BASELINE_CH1: baseline_reg[1] <= cfg_data[SB-1:0];
                    lsae_pkg::REG_BASELINE_CH2: baseline_reg[2] <= cfg_data[SB-1:0];
                    lsae_pkg::REG_BASELINE_CH3: baseline_reg[3] <= cfg_data[SB-1:0];
                    lsae_pkg::REG_BASELINE_CH4: baseline_reg[4] <= cfg_data[SB-1:0];
                    lsae_pkg::REG_RUN_SPEED: begin
                        run_speed_reg <= cfg_data[lsae_pkg::SPEED_W-1:0];
                    end
                    lsae_pkg::REG_STOP_DELAY: begin
                        // stop_delay only acts as the countdown reload value,
                        // and the countdown reloads only before the line end
                        if (!end_seen_reg) begin
                            stop_cnt_reg <= ERR_W'(cfg_data[lsae_pkg::DELAY_W-1:0]);
                        end
                    end
                    default: begin
                        // unused index, write dropped
                    end
                endcase
            end
            if (load_out) begin
                last_err_reg <= err_fin;
                end_seen_reg <= end_seen_next;
                stop_cnt_reg <= stop_cnt_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {{(lsae_pkg::M_TDATA_W-19){1'b0}}, speed, end_seen_next,
                            err_adj[ERR_W-1:1]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/lsae_checker.sv -----
// port-level checks of line_sensor_angle_estimator, bound to the top level
// depends on lsae_pkg
module lsae_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input logic                                               aclk,
    input logic                                               aresetn,
    input logic [((lsae_pkg::NUM_CH*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    input logic                                               s_tvalid,
    input logic                                               s_tready,
    input logic [lsae_pkg::M_TDATA_W-1:0]                     m_tdata,
    input logic                                               m_tvalid,
    input logic                                               m_tready,
    input logic                                               cfg_valid,
    input logic                                               cfg_ready,
    input logic [lsae_pkg::CFG_IDX_W-1:0]                     cfg_index,
    input logic [lsae_pkg::CFG_DATA_W-1:0]                    cfg_data
);

    // one frame at a time: after a beat the input does not open again right away
    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input accepted again right after a frame");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat dropped or changed while stalled");

    // halved error stays within -100..100
    a_steer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[7:0]) >= -8'sd100 &&
                      $signed(m_tdata[7:0]) <= 8'sd100))
        else $error("steer_error out of range");

    // no result pending after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind line_sensor_angle_estimator lsae_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lsae_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for line_sensor_angle_estimator: frames in on s_, results
// out on m_, register writes on cfg_; depends on lsae_pkg and the rtl/core sources

module tb;

    localparam int SAMPLE_BITS    = 12;
    localparam int MAX_SAMPLE     = (1 << SAMPLE_BITS) - 1;
    localparam int S_TDATA_W      = ((lsae_pkg::NUM_CH * SAMPLE_BITS + 7) / 8) * 8;
    localparam int DONE_BIT       = lsae_pkg::STEER_W;
    localparam int SPEED_LSB      = lsae_pkg::STEER_W + 1;
    localparam int SWEEP_PHASES   = 9;
    localparam int SWEEP_FRAMES   = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [lsae_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] frame_t;

    typedef struct packed {
        logic signed [lsae_pkg::STEER_W-1:0] steer;
        logic                                done;
        logic [lsae_pkg::SPEED_W-1:0]        speed;
    } steer_res_t;

    typedef enum int {FR_LINE, FR_NOISE, FR_DARK, FR_TIE} frame_kind_t;

    logic                             aclk;
    logic                             aresetn;
    logic [S_TDATA_W-1:0]             s_tdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [lsae_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lsae_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [lsae_pkg::CFG_DATA_W-1:0]  cfg_data;

    // tracked copy of the block's registers and state
    int base_lvl [lsae_pkg::NUM_CH];
    int run_spd;
    int stop_dly;
    int prev_err;
    bit line_ended;
    int halt_count;

    steer_res_t steer_results_q [$];

    int  mismatches;
    int  n_frames;
    int  n_checked;
    int  n_no_line;
    int  n_halted;
    int  quiet_cycles;
    bit  idle_on;
    bit  hold_sink_req;
    int  hold_sink_len;

    line_sensor_angle_estimator #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    task automatic reset_tracking();
        for (int i = 0; i < lsae_pkg::NUM_CH; i++) base_lvl[i] = 0;
        run_spd    = lsae_pkg::RESET_SPEED;
        stop_dly   = lsae_pkg::RESET_DELAY;
        prev_err   = 0;
        line_ended = 1'b0;
        halt_count = lsae_pkg::RESET_DELAY;
    endtask

    // bits above each register's width are dropped by the block
    task automatic apply_reg(lsae_pkg::cfg_reg_t idx,
                             logic [lsae_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsae_pkg::REG_RUN_SPEED: run_spd = int'(data[lsae_pkg::SPEED_W-1:0]);
            lsae_pkg::REG_STOP_DELAY: begin
                stop_dly = int'(data[lsae_pkg::DELAY_W-1:0]);
                // the countdown only reloads before the line end
                if (!line_ended) halt_count = stop_dly;
            end
            default: base_lvl[int'(idx)] = int'(data[SAMPLE_BITS-1:0]);
        endcase
    endtask

    function automatic steer_res_t interpolate_angle(frame_t f);
        int lvl [lsae_pkg::NUM_CH];
        int best;
        int sel;
        int err;
        int speed;
        bit all_on;
        steer_res_t r;
        best   = lsae_pkg::LINE_THRESH;
        sel    = -1;
        all_on = 1'b1;
        // baseline removal, clamped at zero
        for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
            lvl[i] = int'(f[i]) - base_lvl[i];
            if (lvl[i] < 0) lvl[i] = 0;
        end
        // strict compare: lowest channel wins a tie
        for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
            if (lvl[i] < lsae_pkg::LINE_THRESH) all_on = 1'b0;
            if (lvl[i] > best) begin
                best = lvl[i];
                sel  = i;
            end
        end
        if (all_on) line_ended = 1'b1;
        // sv integer division truncates toward zero
        case (sel)
            0: err = -lsae_pkg::EDGE_ERR + (100 * lvl[1]) / (lvl[0] + lvl[1]);
            1: err = -100 + (50 * (lvl[2] - lvl[0])) / lvl[1];
            2: err = (50 * (lvl[3] - lvl[1])) / lvl[2];
            3: err = 100 + (50 * (lvl[4] - lvl[2])) / lvl[3];
            4: err = lsae_pkg::EDGE_ERR - (100 * lvl[3]) / (lvl[3] + lvl[4]);
            default: begin
                // line lost: push to the edge on the side it was last seen
                err = prev_err > 0 ? lsae_pkg::EDGE_ERR
                                   : (prev_err < 0 ? -lsae_pkg::EDGE_ERR : 0);
                n_no_line++;
            end
        endcase
        if (err > lsae_pkg::EDGE_ERR) err = lsae_pkg::EDGE_ERR;
        if (err < -lsae_pkg::EDGE_ERR) err = -lsae_pkg::EDGE_ERR;
        prev_err = err;
        if (line_ended && halt_count >= 0) halt_count--;
        speed = halt_count < 0 ? 0 : run_spd;
        if (halt_count < 0) n_halted++;
        r.steer = lsae_pkg::STEER_W'(err / 2);
        r.done  = line_ended;
        r.speed = lsae_pkg::SPEED_W'(speed);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_gap();
        int r;
        if (!idle_on) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 88) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic frame_t frame5(int a, int b, int c, int d, int e);
        frame_t f;
        f[0] = sample_t'(a);
        f[1] = sample_t'(b);
        f[2] = sample_t'(c);
        f[3] = sample_t'(d);
        f[4] = sample_t'(e);
        return f;
    endfunction

    // raw sample that reads lvl above the channel's baseline, saturated
    function automatic sample_t lift(int i, int lvl);
        int v;
        v = base_lvl[i] + lvl;
        if (v > MAX_SAMPLE) v = MAX_SAMPLE;
        return sample_t'(v);
    endfunction

    function automatic frame_t make_frame(frame_kind_t kind, bit allow_end);
        frame_t f;
        int c;
        int c2;
        int peak;
        int d;
        int k;
        int lim;
        bit all_on;
        case (kind)
            FR_LINE: begin
                // peak with falling neighbours, small peaks now and then
                c    = int'($urandom_range(0, lsae_pkg::NUM_CH - 1));
                peak = ($urandom_range(0, 3) == 0) ? int'($urandom_range(9, 40))
                                                   : int'($urandom_range(9, MAX_SAMPLE));
                for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
                    d = i > c ? i - c : c - i;
                    if (d == 0) f[i] = lift(i, peak);
                    else if (d == 1) f[i] = lift(i, int'($urandom_range(0, peak)));
                    else f[i] = lift(i, int'($urandom_range(0, peak / 3)));
                end
            end
            FR_NOISE: begin
                for (int i = 0; i < lsae_pkg::NUM_CH; i++)
                    f[i] = sample_t'($urandom_range(0, MAX_SAMPLE));
            end
            FR_DARK: begin
                // everything at or under threshold, some below baseline
                for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
                    if (base_lvl[i] > 0 && $urandom_range(0, 3) == 0)
                        f[i] = sample_t'($urandom_range(0, base_lvl[i] - 1));
                    else
                        f[i] = lift(i, int'($urandom_range(0, lsae_pkg::LINE_THRESH)));
                end
            end
            default: begin
                // two channels share the maximum
                c    = int'($urandom_range(0, lsae_pkg::NUM_CH - 2));
                c2   = int'($urandom_range(c + 1, lsae_pkg::NUM_CH - 1));
                peak = int'($urandom_range(9, MAX_SAMPLE));
                for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
                    if (i == c || i == c2) f[i] = lift(i, peak);
                    else f[i] = lift(i, int'($urandom_range(0, peak - 1)));
                end
            end
        endcase
        if (!allow_end) begin
            // keep the sticky line end away until its own test
            all_on = 1'b1;
            for (int i = 0; i < lsae_pkg::NUM_CH; i++)
                if (int'(f[i]) - base_lvl[i] < lsae_pkg::LINE_THRESH) all_on = 1'b0;
            if (all_on) begin
                k   = int'($urandom_range(0, lsae_pkg::NUM_CH - 1));
                lim = base_lvl[k] + lsae_pkg::LINE_THRESH - 1;
                if (lim > MAX_SAMPLE) lim = MAX_SAMPLE;
                f[k] = sample_t'($urandom_range(0, lim));
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one frame beat; valid stays high into the next beat when no gap is drawn
    task automatic send_frame(frame_t f);
        int gap;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= S_TDATA_W'(f);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        steer_results_q.push_back(interpolate_angle(f));
        n_frames++;
    endtask

    task automatic random_frames(int count, bit allow_end);
        int r;
        frame_kind_t kind;
        for (int n = 0; n < count; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 50) kind = FR_LINE;
            else if (r < 70) kind = FR_NOISE;
            else if (r < 85) kind = FR_DARK;
            else kind = FR_TIE;
            send_frame(make_frame(kind, allow_end));
        end
    endtask

    // drop valid and wait for every outstanding result; block is idle after
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (steer_results_q.size() != 0) @(posedge aclk);
    endtask

    // unused upper data bits are filled with noise
    task automatic write_reg(lsae_pkg::cfg_reg_t idx, int value);
        logic [lsae_pkg::CFG_DATA_W-1:0] data;
        data = lsae_pkg::CFG_DATA_W'($urandom());
        case (idx)
            lsae_pkg::REG_RUN_SPEED:
                data[lsae_pkg::SPEED_W-1:0] = lsae_pkg::SPEED_W'(value);
            lsae_pkg::REG_STOP_DELAY:
                data[lsae_pkg::DELAY_W-1:0] = lsae_pkg::DELAY_W'(value);
            default:
                data[SAMPLE_BITS-1:0] = SAMPLE_BITS'(value);
        endcase
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("beat %0d: %s is %0d, predicted %0d", n_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        steer_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (steer_results_q.size() == 0) begin
                report_mismatch("beat with nothing pending, tdata", int'(m_tdata), 0);
            end else begin
                want = steer_results_q.pop_front();
                if ($signed(m_tdata[lsae_pkg::STEER_W-1:0]) != want.steer)
                    report_mismatch("steer_error",
                                    int'($signed(m_tdata[lsae_pkg::STEER_W-1:0])),
                                    int'(want.steer));
                if (m_tdata[DONE_BIT] != want.done)
                    report_mismatch("line_done", int'(m_tdata[DONE_BIT]), int'(want.done));
                if (m_tdata[SPEED_LSB +: lsae_pkg::SPEED_W] != want.speed)
                    report_mismatch("speed_command",
                                    int'(m_tdata[SPEED_LSB +: lsae_pkg::SPEED_W]),
                                    int'(want.speed));
            end
            n_checked++;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink_req) begin
                hold_sink_req = 1'b0;
                stall_left    = hold_sink_len;
            end else if (stall_left == 0) begin
                stall_left = idle_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ends the run when no beat moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("stalled for %0d cycles with %0d results pending",
                         WATCHDOG_LIMIT, steer_results_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values, every selected channel, ties and lost-line cases
    task automatic test_directed_defaults();
        send_frame(frame5(0, 0, 0, 0, 0));              // dark with zero history
        send_frame(frame5(MAX_SAMPLE, 0, 0, 0, 0));      // hard left edge
        send_frame(frame5(0, 0, 0, 0, 0));              // lost on the left
        send_frame(frame5(0, 0, 0, 0, MAX_SAMPLE));      // hard right edge
        send_frame(frame5(8, 8, 8, 8, 7));              // at threshold, lost on the right
        send_frame(frame5(9, 0, 0, 0, 0));              // just above threshold
        send_frame(frame5(4000, MAX_SAMPLE, 0, 0, 0));   // negative truncation
        send_frame(frame5(0, MAX_SAMPLE, MAX_SAMPLE, 0, 0));
        send_frame(frame5(0, 0, MAX_SAMPLE, 0, 0));
        send_frame(frame5(0, 300, 1000, 700, 0));
        send_frame(frame5(0, 0, 10, MAX_SAMPLE, MAX_SAMPLE));
        send_frame(frame5(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 0));
        send_frame(frame5(0, 0, 0, 3000, 4000));
        send_frame(frame5(0, 0, 0, 0, 0));
    endtask

    // baselines at the top end clamp every channel to zero
    task automatic test_baseline_clamp();
        settle();
        for (int i = 0; i < lsae_pkg::NUM_CH; i++)
            write_reg(lsae_pkg::cfg_reg_t'(lsae_pkg::REG_BASELINE_CH0 + i), MAX_SAMPLE);
        send_frame(frame5(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE));
        send_frame(frame5(0, 100, 2000, 4000, 17));
        settle();
        for (int i = 0; i < lsae_pkg::NUM_CH; i++)
            write_reg(lsae_pkg::cfg_reg_t'(lsae_pkg::REG_BASELINE_CH0 + i),
                      i == 2 ? MAX_SAMPLE : 0);
        send_frame(frame5(50, 50, MAX_SAMPLE, 50, 50));
    endtask

    // random frames under a series of register settings, extremes first
    task automatic test_config_sweep();
        int b;
        for (int p = 0; p < SWEEP_PHASES; p++) begin
            settle();
            for (int i = 0; i < lsae_pkg::NUM_CH; i++) begin
                if (p == 0) b = 0;
                else if (p == 1) b = int'($urandom_range(0, 63));
                else if ($urandom_range(0, 7) == 0) b = int'($urandom_range(0, MAX_SAMPLE));
                else b = int'($urandom_range(0, 300));
                write_reg(lsae_pkg::cfg_reg_t'(lsae_pkg::REG_BASELINE_CH0 + i), b);
            end
            write_reg(lsae_pkg::REG_RUN_SPEED,
                      p == 0 ? 0 : (p == 1 ? 1023 : int'($urandom_range(0, 1023))));
            write_reg(lsae_pkg::REG_STOP_DELAY,
                      p == 0 ? 0 : (p == 1 ? 255 : int'($urandom_range(0, 255))));
            // every third phase runs back to back with no idling
            idle_on = (p % 3) != 2;
            random_frames(SWEEP_FRAMES, 1'b0);
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while frames keep coming, so the input backs up
    task automatic test_receiver_hold();
        settle();
        idle_on       = 1'b0;
        hold_sink_len = HOLD_CYCLES;
        hold_sink_req = 1'b1;
        random_frames(20, 1'b0);
        idle_on = 1'b1;
    endtask

    // line end, countdown, late stop_delay write, speed held at zero
    task automatic test_line_end();
        frame_t f;
        settle();
        for (int i = 0; i < lsae_pkg::NUM_CH; i++)
            write_reg(lsae_pkg::cfg_reg_t'(lsae_pkg::REG_BASELINE_CH0 + i),
                      int'($urandom_range(0, 200)));
        write_reg(lsae_pkg::REG_RUN_SPEED, int'($urandom_range(1, 1023)));
        write_reg(lsae_pkg::REG_STOP_DELAY, int'($urandom_range(20, 60)));
        // every channel exactly at threshold: line end with no line chosen
        for (int i = 0; i < lsae_pkg::NUM_CH; i++) f[i] = lift(i, lsae_pkg::LINE_THRESH);
        send_frame(f);
        random_frames(5, 1'b1);
        // countdown must not reload after the line end
        settle();
        write_reg(lsae_pkg::REG_STOP_DELAY, 255);
        random_frames(380, 1'b1);
        settle();
        write_reg(lsae_pkg::REG_RUN_SPEED, 1023);
        random_frames(30, 1'b1);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = lsae_pkg::REG_BASELINE_CH0;
        cfg_data      = '0;
        mismatches    = 0;
        n_frames      = 0;
        n_checked     = 0;
        n_no_line     = 0;
        n_halted      = 0;
        quiet_cycles  = 0;
        idle_on       = 1'b1;
        hold_sink_req = 1'b0;
        hold_sink_len = 0;
        reset_tracking();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_defaults();
        test_baseline_clamp();
        test_config_sweep();
        test_receiver_hold();
        test_line_end();

        settle();
        repeat (40) @(posedge aclk);

        $display("ran %0d frames and checked %0d result beats across %0d register settings",
                 n_frames, n_checked, SWEEP_PHASES + 3);
        $display("%0d frames saw no line, %0d frames ran with the speed stopped",
                 n_no_line, n_halted);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
